### sv/lsbh_pkg.sv
// Shared types and constants for the lookup3 string bucket hash.
package lsbh_pkg;

  localparam int unsigned MAX_KEY_BYTES_DEF = 32'd65535;
  localparam logic [31:0] SEED_BASE = 32'hdeadbeef;
  localparam logic [31:0] INIT_VALUE = 32'd42;
  localparam logic [31:0] SEED_INIT = SEED_BASE + INIT_VALUE;
  localparam logic [31:0] TABLE_SIZE_RESET = 32'd1024;

  localparam int WORD_W = 32;
  localparam int LEN_W = 16;
  localparam int POS_W = 4;
  localparam int ROUND_W = 3;

  // last byte index inside a 12-byte block
  localparam logic [POS_W-1:0] POS_LAST = 4'd11;
  localparam logic [ROUND_W-1:0] MIX_LAST_ROUND = 3'd5;
  localparam logic [ROUND_W-1:0] FIN_LAST_ROUND = 3'd6;

  typedef struct packed {
    logic               load;       // item accepted this cycle
    logic               mix;        // one mix row
    logic               fin;        // one final row
    logic [ROUND_W-1:0] round;
    logic               div_start;
    logic               put;        // load the output register
  } cmd_t;

  typedef struct packed {
    logic ignore;   // no key in progress and no first flag
    logic empty;    // first item with zero length
    logic early;    // last flag before the declared end
    logic done;     // item completes the key
    logic full;     // item fills a block that is not the last
    logic div_busy;
    logic div_done;
  } status_t;

endpackage

### sv/lsbh_div.sv
// Restoring divider, one quotient bit per cycle, remainder only.
module lsbh_div
  import lsbh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [WORD_W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [WORD_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(WORD_W);

  logic [WORD_W-1:0] dvd_q, dvd_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [WORD_W:0]   shifted;

  // A zero divisor never restores, so the remainder ends as the dividend.
  always_comb begin
    shifted = {rem_q, dvd_q[WORD_W-1]};
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[WORD_W-2:0], 1'b0};
      if (shifted >= {1'b0, divisor_i}) begin
        rem_d = WORD_W'(shifted - {1'b0, divisor_i});
      end else begin
        rem_d = shifted[WORD_W-1:0];
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

### sv/lsbh_dp.sv
// Datapath: hash words, byte absorb, mix/final rows, bucket divider, result register.
module lsbh_dp
  import lsbh_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic [7:0]        key_byte_i,
  input  logic              is_first_i,
  input  logic              is_last_i,
  input  logic [LEN_W-1:0]  key_length_i,
  input  logic              cfg_we_i,
  input  logic [WORD_W-1:0] cfg_wdata_i,
  output logic [WORD_W-1:0] bucket_o,
  output logic [WORD_W-1:0] raw_hash_o,
  output logic              length_error_o
);

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int k);
    return (x << k) | (x >> (WORD_W - k));
  endfunction

  logic [WORD_W-1:0] a_q, a_d, b_q, b_d, c_q, c_d;
  logic [LEN_W-1:0]  bl_q, bl_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              err_q, err_d;
  logic              early_q, early_d;
  logic [WORD_W-1:0] table_size_q;
  logic [WORD_W-1:0] bucket_q, raw_q;
  logic              lerr_q;

  logic [LEN_W-1:0]  len_sat, bl_eff;
  logic [POS_W-1:0]  pos_eff, pos_nxt;
  logic [WORD_W-1:0] init, base_a, base_b, base_c, add;
  logic              ignore, empty, early, done, full;
  logic              div_busy, div_done;
  logic [WORD_W-1:0] div_rem;

  always_comb begin
    len_sat = key_length_i;
    if (32'(key_length_i) > MAX_KEY_BYTES) begin
      len_sat = MAX_KEY_BYTES[LEN_W-1:0];
    end
    init    = SEED_INIT + 32'(len_sat);
    bl_eff  = is_first_i ? len_sat : bl_q;
    pos_eff = is_first_i ? '0 : pos_q;
    base_a  = is_first_i ? init : a_q;
    base_b  = is_first_i ? init : b_q;
    base_c  = is_first_i ? init : c_q;
    pos_nxt = pos_eff + 1'b1;
    add     = 32'(key_byte_i) << {pos_eff[1:0], 3'b000};

    ignore = !is_first_i && (bl_q == '0);
    empty  = is_first_i && (len_sat == '0);
    early  = !empty && is_last_i && (bl_eff > 16'd1);
    done   = !empty && !early && (bl_eff == 16'd1);
    full   = !empty && !early && !done && (pos_eff == POS_LAST);
  end

  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    bl_d    = bl_q;
    pos_d   = pos_q;
    err_d   = err_q;
    early_d = early_q;
    if (cmd_i.load && !ignore) begin
      a_d = base_a;
      b_d = base_b;
      c_d = base_c;
      if (empty) begin
        bl_d    = '0;
        pos_d   = '0;
        err_d   = !is_last_i;
        early_d = 1'b0;
      end else if (early) begin
        bl_d    = '0;
        pos_d   = '0;
        err_d   = 1'b1;
        early_d = 1'b1;
      end else begin
        case (pos_eff[3:2])
          2'd0:    a_d = base_a + add;
          2'd1:    b_d = base_b + add;
          default: c_d = base_c + add;
        endcase
        bl_d    = bl_eff - 1'b1;
        pos_d   = (done || full) ? '0 : pos_nxt;
        err_d   = !is_last_i;
        early_d = 1'b0;
      end
    end else if (cmd_i.mix) begin
      case (cmd_i.round)
        3'd0: begin a_d = (a_q - c_q) ^ rotl(c_q, 4);  c_d = c_q + b_q; end
        3'd1: begin b_d = (b_q - a_q) ^ rotl(a_q, 6);  a_d = a_q + c_q; end
        3'd2: begin c_d = (c_q - b_q) ^ rotl(b_q, 8);  b_d = b_q + a_q; end
        3'd3: begin a_d = (a_q - c_q) ^ rotl(c_q, 16); c_d = c_q + b_q; end
        3'd4: begin b_d = (b_q - a_q) ^ rotl(a_q, 19); a_d = a_q + c_q; end
        default: begin c_d = (c_q - b_q) ^ rotl(b_q, 4); b_d = b_q + a_q; end
      endcase
    end else if (cmd_i.fin) begin
      case (cmd_i.round)
        3'd0: c_d = (c_q ^ b_q) - rotl(b_q, 14);
        3'd1: a_d = (a_q ^ c_q) - rotl(c_q, 11);
        3'd2: b_d = (b_q ^ a_q) - rotl(a_q, 25);
        3'd3: c_d = (c_q ^ b_q) - rotl(b_q, 16);
        3'd4: a_d = (a_q ^ c_q) - rotl(c_q, 4);
        3'd5: b_d = (b_q ^ a_q) - rotl(a_q, 14);
        default: c_d = (c_q ^ b_q) - rotl(b_q, 24);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q          <= '0;
      b_q          <= '0;
      c_q          <= '0;
      bl_q         <= '0;
      pos_q        <= '0;
      err_q        <= 1'b0;
      early_q      <= 1'b0;
      table_size_q <= TABLE_SIZE_RESET;
    end else begin
      a_q     <= a_d;
      b_q     <= b_d;
      c_q     <= c_d;
      bl_q    <= bl_d;
      pos_q   <= pos_d;
      err_q   <= err_d;
      early_q <= early_d;
      if (cfg_we_i) begin
        table_size_q <= cfg_wdata_i;
      end
    end
  end

  lsbh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (c_q),
    .divisor_i  (table_size_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // an early last flag reports zeros
  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      bucket_q <= early_q ? '0 : div_rem;
      raw_q    <= early_q ? '0 : c_q;
      lerr_q   <= err_q;
    end
  end

  assign status_o = '{ignore: ignore, empty: empty, early: early, done: done,
                      full: full, div_busy: div_busy, div_done: div_done};

  assign bucket_o       = bucket_q;
  assign raw_hash_o     = raw_q;
  assign length_error_o = lerr_q;

endmodule

### sv/lsbh_ctrl.sv
// Controller: sequences absorb, mix rounds, final rounds, bucket divide and result hand-off.
module lsbh_ctrl
  import lsbh_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX,
    S_FIN,
    S_DIVGO,
    S_DIV,
    S_PUT
  } state_e;

  state_e             state_q, state_d;
  logic [ROUND_W-1:0] round_q, round_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.round = round_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
        round_d    = '0;
        if (in_valid_i && !status_i.ignore) begin
          if (status_i.empty) begin
            state_d = S_DIVGO;
          end else if (status_i.early) begin
            state_d = S_PUT;
          end else if (status_i.done) begin
            state_d = S_FIN;
          end else if (status_i.full) begin
            state_d = S_MIX;
          end
        end
      end
      S_MIX: begin
        cmd_o.mix = 1'b1;
        round_d   = round_q + 1'b1;
        if (round_q == MIX_LAST_ROUND) begin
          state_d = S_IDLE;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        round_d   = round_q + 1'b1;
        if (round_q == FIN_LAST_ROUND) begin
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (out_free) begin
          cmd_o.put   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### sv/lookup3_string_bucket_hash.sv
// Top level: streaming lookup3 string hash with bucket reduction.
//
//   channel | handshake                 | payload
//   in      | in_valid_i / in_ready_o   | key_byte_i, is_first_i, is_last_i, key_length_i
//   out     | out_valid_o / out_ready_i | bucket_o, raw_hash_o, length_error_o
//   cfg     | cfg_we_i                  | cfg_wdata_i (table size)
//
// A byte item is taken while in_ready_o is high; a byte that closes a 12-byte block that
// is not the last is followed by 6 mix rows, one row per cycle.
// The closing byte is followed by 7 final rows, a divider start, the divider's
// 32 remainder bits and its done flag, then a load into the output register.
// An empty key skips the final rows; an early last flag goes straight out.
// Reset clears the words, counters and handshakes and sets the table size
// to 1024. A result waiting on out_ready_i holds the next key at its end.
module lookup3_string_bucket_hash
  import lsbh_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        key_byte_i,
  input  logic              is_first_i,
  input  logic              is_last_i,
  input  logic [LEN_W-1:0]  key_length_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] bucket_o,
  output logic [WORD_W-1:0] raw_hash_o,
  output logic              length_error_o,
  input  logic              cfg_we_i,
  input  logic [WORD_W-1:0] cfg_wdata_i
);

  cmd_t    cmd;
  status_t status;

  lsbh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lsbh_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .key_byte_i     (key_byte_i),
    .is_first_i     (is_first_i),
    .is_last_i      (is_last_i),
    .key_length_i   (key_length_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .bucket_o       (bucket_o),
    .raw_hash_o     (raw_hash_o),
    .length_error_o (length_error_o)
  );

`ifndef SYNTH
  // no item is taken while the divider runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.div_busy |-> !in_ready_o)
    else $error("item accepted during bucket divide");

  // a remainder never exceeds its dividend
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (bucket_o <= raw_hash_o))
    else $error("bucket larger than raw hash");

  // mix rows, final rows and divide starts never overlap an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!cmd.mix && !cmd.fin && !cmd.div_start))
    else $error("round command while ready");

  // a divide start is followed by a busy divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> status.div_busy)
    else $error("divider did not start");
`endif

endmodule

### tb/sv/lookup3_string_bucket_hash_tb.sv
// Testbench for lookup3_string_bucket_hash: directed and random keys checked against a local model.
module lookup3_string_bucket_hash_tb;
  import lsbh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;
  localparam int DRAIN_CYCLES = 64;  // 6 mix rows or 7 final rows + divider + output
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  typedef struct packed {
    logic [WORD_W-1:0] bucket;
    logic [WORD_W-1:0] raw;
    logic              len_err;
  } hash_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [7:0]        key_byte_i = '0;
  logic              is_first_i = 1'b0;
  logic              is_last_i = 1'b0;
  logic [LEN_W-1:0]  key_length_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [WORD_W-1:0] bucket_o;
  logic [WORD_W-1:0] raw_hash_o;
  logic              length_error_o;
  logic              cfg_we_i = 1'b0;
  logic [WORD_W-1:0] cfg_wdata_i = '0;

  // local copy of the hash state
  logic [WORD_W-1:0] ha, hb, hc;
  logic [WORD_W-1:0] bucket_count = TABLE_SIZE_RESET;
  logic [LEN_W-1:0]  bytes_due = '0;
  logic [POS_W-1:0]  blk_pos = '0;
  hash_result_t      hashes_due[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  int errors = 0;
  int items_live = 0;
  int results_seen = 0;
  int sizes_used = 0;

  lookup3_string_bucket_hash uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .key_byte_i    (key_byte_i),
    .is_first_i    (is_first_i),
    .is_last_i     (is_last_i),
    .key_length_i  (key_length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .bucket_o      (bucket_o),
    .raw_hash_o    (raw_hash_o),
    .length_error_o(length_error_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] x, input int k);
    return (x << k) | (x >> (WORD_W - k));
  endfunction

  task automatic mix_rows();
    ha -= hc; ha ^= rol(hc, 4);  hc += hb;
    hb -= ha; hb ^= rol(ha, 6);  ha += hc;
    hc -= hb; hc ^= rol(hb, 8);  hb += ha;
    ha -= hc; ha ^= rol(hc, 16); hc += hb;
    hb -= ha; hb ^= rol(ha, 19); ha += hc;
    hc -= hb; hc ^= rol(hb, 4);  hb += ha;
  endtask

  task automatic final_rows();
    hc ^= hb; hc -= rol(hb, 14);
    ha ^= hc; ha -= rol(hc, 11);
    hb ^= ha; hb -= rol(ha, 25);
    hc ^= hb; hc -= rol(hb, 16);
    ha ^= hc; ha -= rol(hc, 4);
    hb ^= ha; hb -= rol(ha, 14);
    hc ^= hb; hc -= rol(hb, 24);
  endtask

  task automatic queue_hash_result(input logic [WORD_W-1:0] raw, input logic err,
                                   input logic good);
    hash_result_t r;
    r.raw = good ? raw : '0;
    r.bucket = !good ? '0 : (bucket_count != 0) ? raw % bucket_count : raw;
    r.len_err = err;
    hashes_due.push_back(r);
  endtask

  // Advance the local state by one accepted item.
  task automatic hash_item(input logic [7:0] b, input logic first, input logic last,
                           input logic [LEN_W-1:0] len);
    logic [WORD_W-1:0] add;
    if (first) begin
      ha = SEED_INIT + WORD_W'(len);
      hb = ha;
      hc = ha;
      blk_pos = '0;
      bytes_due = len;
      items_live++;
      if (len == 0) begin
        queue_hash_result(hc, !last, 1'b1);
        return;
      end
    end else if (bytes_due == 0) begin
      return;  // idle, item dropped
    end else begin
      items_live++;
    end
    if (last && bytes_due > 1) begin
      bytes_due = '0;
      blk_pos = '0;
      queue_hash_result('0, 1'b1, 1'b0);
      return;
    end
    add = WORD_W'(b) << (8 * blk_pos[1:0]);
    if (blk_pos < 4) ha += add;
    else if (blk_pos < 8) hb += add;
    else hc += add;
    blk_pos++;
    bytes_due--;
    if (bytes_due == 0) begin
      final_rows();
      blk_pos = '0;
      queue_hash_result(hc, !last, 1'b1);
    end else if (blk_pos > POS_LAST) begin
      mix_rows();
      blk_pos = '0;
    end
  endtask

  // Result check and receiver ready.
  always @(posedge clk_i) begin : out_side
    hash_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (hashes_due.size() == 0) begin
        $error("unexpected result: bucket %h raw_hash %h length_error %b",
               bucket_o, raw_hash_o, length_error_o);
        errors++;
      end else begin
        want = hashes_due.pop_front();
        if (bucket_o !== want.bucket) begin
          $error("bucket: expected %h, got %h", want.bucket, bucket_o);
          errors++;
        end
        if (raw_hash_o !== want.raw) begin
          $error("raw_hash: expected %h, got %h", want.raw, raw_hash_o);
          errors++;
        end
        if (length_error_o !== want.len_err) begin
          $error("length_error: expected %b, got %b", want.len_err, length_error_o);
          errors++;
        end
      end
    end
    if (stall_cycles > 0) begin
      stall_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one item and wait for it to be taken.
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic [LEN_W-1:0] len);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i   <= 1'b1;
    key_byte_i   <= b;
    is_first_i   <= first;
    is_last_i    <= last;
    key_length_i <= len;
    do @(posedge clk_i); while (!in_ready_o);
    hash_item(b, first, last, len);
  endtask

  // Declared length, bytes actually sent, and whether the final byte carries last.
  task automatic send_key(input int declared, input int n_bytes, input logic end_flag);
    int n;
    n = (n_bytes == 0) ? 1 : n_bytes;
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom), i == 0, end_flag && (i == n - 1),
                (i == 0) ? LEN_W'(declared) : LEN_W'($urandom));
  endtask

  function automatic int key_len_pick();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 12 * $urandom_range(0, 3);
    if (r < 75) return $urandom_range(1, 24);
    if (r < 97) return $urandom_range(25, 60);
    return $urandom_range(61, 200);
  endfunction

  task automatic settle();
    in_valid_i <= 1'b0;
    while (hashes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_table_size(input logic [WORD_W-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bucket_count = value;
    sizes_used++;
  endtask

  task automatic test_empty_keys();
    send_byte(8'hff, 1'b1, 1'b1, '0);
    send_byte(8'h00, 1'b1, 1'b0, '0);  // no last flag: error
  endtask

  task automatic test_single_byte_keys();
    send_byte(8'h00, 1'b1, 1'b1, LEN_W'(1));
    send_byte(8'hff, 1'b1, 1'b1, LEN_W'(1));
  endtask

  // 13 bytes: one mixed block, then a one-byte tail
  task automatic test_block_mix();
    for (int i = 0; i < 13; i++)
      send_byte(8'(8'hab + i * 8'h15), i == 0, i == 12, LEN_W'(13));
  endtask

  task automatic test_length_flags();
    send_byte(8'hff, 1'b1, 1'b0, '1);  // longest declared key, cut short
    send_byte(8'h00, 1'b0, 1'b1, '0);
    send_byte(8'ha5, 1'b1, 1'b0, LEN_W'(2));
    send_byte(8'h5a, 1'b0, 1'b0, '1);  // end reached without last
  endtask

  task automatic test_idle_and_restart();
    send_byte(8'h77, 1'b0, 1'b1, '1);  // dropped while idle
    send_byte(8'h11, 1'b1, 1'b0, LEN_W'(5));
    send_byte(8'h22, 1'b0, 1'b0, '0);
    send_byte(8'h33, 1'b1, 1'b1, LEN_W'(1));
  endtask

  task automatic test_random_keys(input int n_items, input int s_pct, input int r_pct);
    int goal, kind, d, n;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    goal = items_live + n_items;
    while (items_live < goal) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        n = key_len_pick();
        send_key(n, n, 1'b1);
      end else if (kind < 78) begin
        n = key_len_pick();
        send_key(n, n, 1'b0);
      end else if (kind < 94) begin
        // cut-off key: early last, or left open so the next key restarts it
        d = $urandom_range(2, 65535);
        n = $urandom_range(1, (d < 9) ? d - 1 : 8);
        send_key(d, n, kind < 86);
      end else begin
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom), 1'b0, 1'($urandom_range(1)), LEN_W'($urandom));
      end
    end
  endtask

  task automatic test_zero_table_size();
    int n;
    write_table_size('0);
    send_key(0, 0, 1'b1);
    repeat (10) begin
      n = key_len_pick();
      send_key(n, n, 1'b1);
    end
  endtask

  // Receiver stops for a long stretch while short keys keep coming.
  task automatic test_backpressure();
    int n;
    write_table_size(32'd3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_cycles = 400;
    repeat (40) begin
      n = $urandom_range(1, 3);
      send_key(n, n, 1'b1);
    end
  endtask

  initial begin
    ha = '0;
    hb = '0;
    hc = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 27;
    recv_idle_pct = 84;
    test_empty_keys();
    test_single_byte_keys();
    test_block_mix();
    test_length_flags();
    test_idle_and_restart();

    write_table_size(32'd1);
    test_random_keys(200, 27, 84);
    write_table_size('1);
    test_random_keys(200, 84, 27);
    write_table_size(WORD_W'($urandom_range(2, 5000)));
    test_random_keys(100, 0, 0);
    write_table_size(WORD_W'($urandom));
    test_random_keys(100, 0, 0);
    test_zero_table_size();
    test_backpressure();

    settle();
    $display("covered %0d hashed items, %0d results, %0d table sizes",
             items_live, results_seen, sizes_used);
    $display("keys: empty, single byte, block edges, early and missing last, restarts, long stall");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results outstanding", hashes_due.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
